// ===== rtl/core/pllm_pkg.sv =====
// Pooled linked list manager: shared types, sizes and operation codes.
// No dependencies; every other file in rtl/core imports this package.
package pllm_pkg;

  localparam int NODES  = 64;
  localparam int LISTS  = 8;
  localparam int ITEM_W = 32;
  localparam int IDX_W  = $clog2(NODES);
  localparam int PTR_W  = IDX_W + 1;
  localparam int LID_W  = 3;
  localparam int CNT_W  = 7;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ITEM_W-1:0] item_t;
  typedef logic [LID_W-1:0]  lid_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [2:0]        flags_t;

  localparam ptr_t NIL = PTR_W'(NODES);

  localparam flags_t FL_USE    = 3'b001;
  localparam flags_t FL_BEFORE = 3'b010;
  localparam flags_t FL_AFTER  = 3'b100;

  localparam logic [3:0] MODE_CREATE  = 4'd0;
  localparam logic [3:0] MODE_COUNT   = 4'd1;
  localparam logic [3:0] MODE_FIRST   = 4'd2;
  localparam logic [3:0] MODE_LAST    = 4'd3;
  localparam logic [3:0] MODE_NEXT    = 4'd4;
  localparam logic [3:0] MODE_PREV    = 4'd5;
  localparam logic [3:0] MODE_CURRENT = 4'd6;
  localparam logic [3:0] MODE_ADD     = 4'd7;
  localparam logic [3:0] MODE_INSERT  = 4'd8;
  localparam logic [3:0] MODE_APPEND  = 4'd9;
  localparam logic [3:0] MODE_PREPEND = 4'd10;
  localparam logic [3:0] MODE_REMOVE  = 4'd11;
  localparam logic [3:0] MODE_TRIM    = 4'd12;
  localparam logic [3:0] MODE_CONCAT  = 4'd13;
  localparam logic [3:0] MODE_FREE    = 4'd14;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_POOL   = 2'd1;
  localparam logic [1:0] ST_NOLIST = 2'd2;

  typedef struct packed {
    ptr_t   head;
    ptr_t   tail;
    ptr_t   cur;
    cnt_t   size;
    flags_t flags;
  } head_t;

  localparam head_t HEAD_CLEAR = '{head: NIL, tail: NIL, cur: NIL, size: '0, flags: '0};

  // controller to datapath
  typedef struct packed {
    idx_t  nd_raddr;
    logic  val_we;
    idx_t  val_waddr;
    item_t val_wdata;
    logic  nxt_we;
    idx_t  nxt_waddr;
    ptr_t  nxt_wdata;
    logic  prv_we;
    idx_t  prv_waddr;
    ptr_t  prv_wdata;
    logic  stk_pop;
    logic  stk_push;
    idx_t  stk_wdata;
    lid_t  hd_raddr;
    logic  hd_we;
    lid_t  hd_waddr;
    head_t hd_wdata;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    item_t            nd_val;
    ptr_t             nd_nxt;
    ptr_t             nd_prv;
    idx_t             stk_top;
    logic             stk_empty;
    head_t            hd_q;
    logic [LISTS-1:0] in_use;
  } dp_stat_t;

endpackage

// ===== rtl/core/pllm_req_if.sv =====
// Request channel of the list manager: valid/ready plus one operation.
// Depends on pllm_pkg.
interface pllm_req_if import pllm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  lid_t       list_id;
  lid_t       other_list;
  item_t      item;

  modport source (output valid, mode, list_id, other_list, item, input ready);
  modport sink   (input valid, mode, list_id, other_list, item, output ready);
endinterface

// ===== rtl/core/pllm_rsp_if.sv =====
// Result channel of the list manager: valid/ready plus one result.
// Depends on pllm_pkg.
interface pllm_rsp_if import pllm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  item_t      item_out;
  logic       item_valid;
  lid_t       new_list;
  cnt_t       count;
  logic       last;

  modport source (output valid, status, item_out, item_valid, new_list, count, last,
                  input ready);
  modport sink   (input valid, status, item_out, item_valid, new_list, count, last,
                  output ready);
endinterface

// ===== rtl/core/pooled_linked_list_manager.sv =====
// Top level of the pooled linked list manager: controller plus datapath.
// Depends on pllm_pkg, pllm_req_if, pllm_rsp_if, pllm_dp, pllm_ctrl.
//
//   channel | dir | payload
//   req     | in  | mode, list_id, other_list, item
//   rsp     | out | status, item_out, item_valid, new_list, count, last
//
// One operation at a time; the steps of each request are set by the
// dependent node and head memory accesses of the sequencer.
// Free gives one transfer per item.
// rst is synchronous; head table and free stack state are ready the cycle after.
// A stalled rsp holds the sequencer; a new request is taken while the last
// result of the previous one still waits in the output register.
module pooled_linked_list_manager import pllm_pkg::*; (
  input logic clk,
  input logic rst,
  pllm_req_if.sink   req,
  pllm_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pllm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

  pllm_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// ===== rtl/core/pllm_dp.sv =====
// Datapath: node memories, free node stack and list head table.
// Depends on pllm_pkg; driven by pllm_ctrl through dp_cmd_t.
module pllm_dp import pllm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  item_t val_mem [NODES];
  ptr_t  nxt_mem [NODES];
  ptr_t  prv_mem [NODES];
  idx_t  stk_mem [NODES];
  logic [NODES-1:0] stk_vld;
  cnt_t  depth;
  head_t tbl [LISTS];
  idx_t  pop_idx;

  item_t            nd_val_q;
  ptr_t             nd_nxt_q;
  ptr_t             nd_prv_q;
  idx_t             stk_top_q;
  head_t            hd_q;
  logic [LISTS-1:0] in_use;

  always_ff @(posedge clk) begin
    if (cmd.val_we) val_mem[cmd.val_waddr] <= cmd.val_wdata;
    if (cmd.nxt_we) nxt_mem[cmd.nxt_waddr] <= cmd.nxt_wdata;
    if (cmd.prv_we) prv_mem[cmd.prv_waddr] <= cmd.prv_wdata;
    nd_val_q <= val_mem[cmd.nd_raddr];
    nd_nxt_q <= nxt_mem[cmd.nd_raddr];
    nd_prv_q <= prv_mem[cmd.nd_raddr];
  end

  assign pop_idx = idx_t'(depth - cnt_t'(1));

  // Untouched stack slots read as their reset contents.
  always_ff @(posedge clk) begin
    if (cmd.stk_pop && depth != '0)
      stk_top_q <= stk_vld[pop_idx] ? stk_mem[pop_idx] : idx_t'(NODES - 1) - pop_idx;
    if (cmd.stk_push && depth < cnt_t'(NODES))
      stk_mem[depth[IDX_W-1:0]] <= cmd.stk_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= cnt_t'(NODES);
      stk_vld <= '0;
    end else if (cmd.stk_pop && depth != '0) begin
      depth <= depth - cnt_t'(1);
    end else if (cmd.stk_push && depth < cnt_t'(NODES)) begin
      depth                      <= depth + cnt_t'(1);
      stk_vld[depth[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LISTS; i++) tbl[i] <= HEAD_CLEAR;
    end else if (cmd.hd_we) begin
      tbl[cmd.hd_waddr] <= cmd.hd_wdata;
    end
    hd_q <= tbl[cmd.hd_raddr];
  end

  always_comb begin
    for (int i = 0; i < LISTS; i++) in_use[i] = tbl[i].flags[0];
  end

  assign stat = '{nd_val: nd_val_q, nd_nxt: nd_nxt_q, nd_prv: nd_prv_q,
                  stk_top: stk_top_q, stk_empty: (depth == '0), hd_q: hd_q,
                  in_use: in_use};

endmodule

// ===== rtl/core/pllm_ctrl.sv =====
// Controller: sequences each operation over the datapath and drives results.
// Depends on pllm_pkg, pllm_req_if, pllm_rsp_if.
module pllm_ctrl import pllm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pllm_req_if.sink   req,
  pllm_rsp_if.source rsp,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_OP, S_NXT, S_LOADV, S_GETV, S_ALLOC, S_PLACE1, S_PLACE2,
    S_RM2, S_RM3, S_CC2, S_CC3, S_CC4, S_FR0, S_FR1, S_FR2, S_FIN
  } state_t;

  state_t     state;
  logic [3:0] mode_r;
  lid_t       lid, mid_l;
  item_t      item_r;
  head_t      h, hm;
  ptr_t       p, q, n, t;
  item_t      v;
  logic       ok, wb, mid, lastf;
  logic [1:0] r_status;
  lid_t       r_new;
  cnt_t       r_cnt, left, k;

  logic       out_free;
  logic       rsp_load;
  logic       free_found;
  lid_t       free_lid;
  logic       is_add, is_next, mark_set, opp_set, front, back;
  ptr_t       endp, startp, newtail;

  assign out_free = !rsp.valid || rsp.ready;
  assign rsp_load = ((state == S_FIN) || (state == S_FR2)) && out_free;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    free_found = 1'b0;
    free_lid   = '0;
    for (int i = LISTS - 1; i >= 0; i--) begin
      if (!stat.in_use[i]) begin
        free_found = 1'b1;
        free_lid   = lid_t'(i);
      end
    end
  end

  always_comb begin
    is_add   = (mode_r == MODE_ADD) || (mode_r == MODE_INSERT) ||
               (mode_r == MODE_APPEND) || (mode_r == MODE_PREPEND);
    is_next  = (mode_r == MODE_NEXT);
    mark_set = is_next ? h.flags[1] : h.flags[2];
    opp_set  = is_next ? h.flags[2] : h.flags[1];
    endp     = is_next ? h.tail : h.head;
    startp   = is_next ? h.head : h.tail;
    front    = (mode_r == MODE_PREPEND) || ((mode_r != MODE_APPEND) && h.flags[1]);
    back     = (mode_r == MODE_APPEND) || h.flags[2] || (h.cur == NIL);
    newtail  = (q == NIL) ? p : h.tail;
  end

  always_comb begin
    cmd = '0;
    cmd.hd_raddr = lid;
    cmd.hd_waddr = lid;
    cmd.hd_wdata = h;
    case (state)
      S_IDLE:  cmd.hd_raddr = req.list_id;
      S_START: begin
        if (mode_r == MODE_CREATE && free_found) begin
          cmd.hd_we    = 1'b1;
          cmd.hd_waddr = free_lid;
          cmd.hd_wdata = '{head: NIL, tail: NIL, cur: NIL, size: '0, flags: FL_USE};
        end
      end
      S_OP: begin
        cmd.hd_raddr = mid_l;
        cmd.nd_raddr = (mode_r == MODE_TRIM) ? h.tail[IDX_W-1:0] : h.cur[IDX_W-1:0];
        cmd.stk_pop  = is_add && !stat.stk_empty;
      end
      S_LOADV: cmd.nd_raddr = h.cur[IDX_W-1:0];
      S_PLACE1: begin
        cmd.val_we    = 1'b1;
        cmd.val_waddr = n[IDX_W-1:0];
        cmd.val_wdata = item_r;
        cmd.nxt_we    = 1'b1;
        cmd.nxt_waddr = n[IDX_W-1:0];
        cmd.nxt_wdata = q;
        cmd.prv_we    = 1'b1;
        cmd.prv_waddr = n[IDX_W-1:0];
        cmd.prv_wdata = p;
      end
      S_PLACE2: begin
        cmd.nxt_we    = (p != NIL);
        cmd.nxt_waddr = p[IDX_W-1:0];
        cmd.nxt_wdata = n;
        cmd.prv_we    = (q != NIL);
        cmd.prv_waddr = q[IDX_W-1:0];
        cmd.prv_wdata = n;
      end
      S_RM3: begin
        cmd.nxt_we    = (p != NIL);
        cmd.nxt_waddr = p[IDX_W-1:0];
        cmd.nxt_wdata = q;
        cmd.prv_we    = (q != NIL);
        cmd.prv_waddr = q[IDX_W-1:0];
        cmd.prv_wdata = p;
        cmd.stk_push  = 1'b1;
        cmd.stk_wdata = t[IDX_W-1:0];
      end
      S_CC3: begin
        // splice tail of the first list onto head of the second
        cmd.nxt_we    = (h.size != '0) && (hm.size != '0) && (h.tail != NIL);
        cmd.nxt_waddr = h.tail[IDX_W-1:0];
        cmd.nxt_wdata = hm.head;
        cmd.prv_we    = (h.size != '0) && (hm.size != '0) && (hm.head != NIL);
        cmd.prv_waddr = hm.head[IDX_W-1:0];
        cmd.prv_wdata = h.tail;
      end
      S_CC4: begin
        cmd.hd_we    = 1'b1;
        cmd.hd_waddr = mid_l;
        cmd.hd_wdata = HEAD_CLEAR;
      end
      S_FR0: cmd.nd_raddr = n[IDX_W-1:0];
      S_FR2: begin
        cmd.stk_push  = out_free;
        cmd.stk_wdata = n[IDX_W-1:0];
        cmd.hd_we     = out_free && lastf;
        cmd.hd_wdata  = HEAD_CLEAR;
      end
      S_FIN: cmd.hd_we = out_free && wb;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.ready && !rsp_load) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_r <= req.mode;
            lid    <= req.list_id;
            mid_l  <= req.other_list;
            item_r <= req.item;
            state  <= S_START;
          end
        end
        S_START: begin
          h  <= stat.hd_q;
          ok <= 1'b0;
          v  <= '0;
          if (mode_r == MODE_CREATE) begin
            wb       <= 1'b0;
            r_status <= free_found ? ST_OK : ST_POOL;
            r_new    <= free_found ? free_lid : lid_t'(0);
            r_cnt    <= '0;
            state    <= S_FIN;
          end else if (mode_r > MODE_FREE) begin
            wb       <= 1'b0;
            r_status <= ST_OK;
            r_new    <= '0;
            r_cnt    <= stat.in_use[lid] ? stat.hd_q.size : cnt_t'(0);
            state    <= S_FIN;
          end else if (!stat.in_use[lid] ||
                       (mode_r == MODE_CONCAT && !stat.in_use[mid_l])) begin
            wb       <= 1'b0;
            r_status <= ST_NOLIST;
            r_new    <= '0;
            r_cnt    <= '0;
            state    <= S_FIN;
          end else begin
            wb       <= 1'b1;
            r_status <= ST_OK;
            r_new    <= '0;
            r_cnt    <= '0;
            state    <= S_OP;
          end
        end
        S_OP: begin
          case (mode_r)
            MODE_FIRST, MODE_LAST: begin
              h.cur   <= (mode_r == MODE_FIRST) ? h.head : h.tail;
              h.flags <= FL_USE;
              state   <= S_LOADV;
            end
            MODE_NEXT, MODE_PREV: begin
              if (mark_set) begin
                h.cur   <= startp;
                h.flags <= FL_USE;
                state   <= S_LOADV;
              end else if (opp_set || h.cur == NIL || h.cur == endp) begin
                h.cur   <= NIL;
                h.flags <= FL_USE | (is_next ? FL_AFTER : FL_BEFORE);
                state   <= S_LOADV;
              end else begin
                state <= S_NXT;
              end
            end
            MODE_CURRENT: state <= S_LOADV;
            MODE_ADD, MODE_INSERT, MODE_APPEND, MODE_PREPEND: begin
              if (stat.stk_empty) begin
                r_status <= ST_POOL;
                wb       <= 1'b0;
                r_cnt    <= h.size;
                state    <= S_FIN;
              end else begin
                mid   <= !front && !back;
                p     <= front ? NIL : h.tail;
                q     <= front ? h.head : NIL;
                state <= S_ALLOC;
              end
            end
            MODE_REMOVE: begin
              if (h.flags[1] || h.flags[2] || h.cur == NIL) state <= S_FIN;
              else begin
                t     <= h.cur;
                state <= S_RM2;
              end
            end
            MODE_TRIM: begin
              if (h.size == '0 || h.tail == NIL) state <= S_FIN;
              else begin
                t     <= h.tail;
                state <= S_RM2;
              end
            end
            MODE_CONCAT: state <= (lid != mid_l) ? S_CC2 : S_FIN;
            MODE_FREE: begin
              n     <= h.head;
              left  <= h.size;
              k     <= '0;
              state <= S_FR0;
            end
            default: state <= S_FIN;
          endcase
        end
        S_NXT: begin
          h.cur <= is_next ? stat.nd_nxt : stat.nd_prv;
          state <= S_LOADV;
        end
        S_LOADV: state <= (h.cur == NIL) ? S_FIN : S_GETV;
        S_GETV: begin
          v     <= stat.nd_val;
          ok    <= 1'b1;
          state <= S_FIN;
        end
        S_ALLOC: begin
          n <= PTR_W'(stat.stk_top);
          if (mid) begin
            if (mode_r == MODE_ADD) begin
              p <= h.cur;
              q <= stat.nd_nxt;
            end else begin
              p <= stat.nd_prv;
              q <= h.cur;
            end
          end
          state <= S_PLACE1;
        end
        S_PLACE1: state <= S_PLACE2;
        S_PLACE2: begin
          if (p == NIL) h.head <= n;
          if (q == NIL) h.tail <= n;
          h.size  <= h.size + cnt_t'(1);
          h.cur   <= n;
          h.flags <= h.flags & FL_USE;
          state   <= S_FIN;
        end
        S_RM2: begin
          p     <= stat.nd_prv;
          q     <= stat.nd_nxt;
          v     <= stat.nd_val;
          ok    <= 1'b1;
          state <= S_RM3;
        end
        S_RM3: begin
          if (p == NIL) h.head <= q;
          if (q == NIL) h.tail <= p;
          if (h.size != '0) h.size <= h.size - cnt_t'(1);
          if (mode_r == MODE_TRIM) begin
            h.cur   <= newtail;
            h.flags <= FL_USE;
          end else begin
            h.cur <= (q != NIL) ? q : newtail;
          end
          state <= S_FIN;
        end
        S_CC2: begin
          hm    <= stat.hd_q;
          state <= S_CC3;
        end
        S_CC3: begin
          if (h.size == '0) begin
            h <= '{head: hm.head, tail: hm.tail, cur: hm.cur, size: hm.size,
                   flags: FL_USE | (hm.flags & (FL_BEFORE | FL_AFTER))};
          end else if (hm.size != '0) begin
            h.tail <= hm.tail;
            h.size <= h.size + hm.size;
          end
          state <= S_CC4;
        end
        S_CC4: state <= S_FIN;
        S_FR0: begin
          if (n != NIL && left != '0) begin
            state <= S_FR1;
          end else begin
            h     <= HEAD_CLEAR;
            state <= S_FIN;
          end
        end
        S_FR1: begin
          v     <= stat.nd_val;
          q     <= stat.nd_nxt;
          left  <= left - cnt_t'(1);
          lastf <= (stat.nd_nxt == NIL) || (left == cnt_t'(1)) || (k == cnt_t'(NODES - 1));
          state <= S_FR2;
        end
        S_FR2: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= ST_OK;
            rsp.item_out   <= v;
            rsp.item_valid <= 1'b1;
            rsp.new_list   <= '0;
            rsp.count      <= left;
            rsp.last       <= lastf;
            k              <= k + cnt_t'(1);
            n              <= q;
            state          <= lastf ? S_IDLE : S_FR0;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= r_status;
            rsp.item_out   <= ok ? v : '0;
            rsp.item_valid <= ok;
            rsp.new_list   <= r_new;
            rsp.count      <= wb ? h.size : r_cnt;
            rsp.last       <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/pooled_linked_list_manager_tb.sv =====
// Self-checking testbench for the pooled linked list manager: an in-bench predictor
// of the node pool and list heads checks every transfer on the result channel.
// Depends on pllm_pkg, pllm_req_if, pllm_rsp_if and pooled_linked_list_manager.
module pooled_linked_list_manager_tb;
  import pllm_pkg::*;

  localparam logic [3:0] MODE_NOP = 4'd15;

  typedef struct {
    logic [1:0] status;
    item_t      item;
    logic       item_valid;
    lid_t       new_list;
    cnt_t       count;
    logic       last;
  } rsp_t;

  logic clk;
  logic rst;

  pllm_req_if req ();
  pllm_rsp_if rsp ();

  pooled_linked_list_manager i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // predicted block state
  item_t  node_item [NODES];
  ptr_t   node_nxt [NODES];
  ptr_t   node_prv [NODES];
  idx_t   pool_stack [NODES];
  int     pool_depth;
  ptr_t   lst_head [LISTS];
  ptr_t   lst_tail [LISTS];
  ptr_t   lst_cur [LISTS];
  cnt_t   lst_size [LISTS];
  flags_t lst_flags [LISTS];

  rsp_t pending_rsp[$];
  int   errors = 0;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_cycles;
  int   hold_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2000000);
    $display("pooled_linked_list_manager_tb: FAIL");
    $finish;
  end

  function automatic ptr_t link_next(ptr_t n);
    return (n < NODES) ? node_nxt[n[IDX_W-1:0]] : NIL;
  endfunction

  function automatic ptr_t link_prev(ptr_t n);
    return (n < NODES) ? node_prv[n[IDX_W-1:0]] : NIL;
  endfunction

  function automatic item_t node_val(ptr_t n);
    return (n < NODES) ? node_item[n[IDX_W-1:0]] : '0;
  endfunction

  function automatic bit is_live(lid_t l);
    return lst_flags[l][0];
  endfunction

  task automatic set_next(ptr_t n, ptr_t v);
    if (n < NODES) node_nxt[n[IDX_W-1:0]] = v;
  endtask

  task automatic set_prev(ptr_t n, ptr_t v);
    if (n < NODES) node_prv[n[IDX_W-1:0]] = v;
  endtask

  task automatic clear_list(lid_t l);
    lst_head[l] = NIL;
    lst_tail[l] = NIL;
    lst_cur[l] = NIL;
    lst_size[l] = '0;
    lst_flags[l] = '0;
  endtask

  task automatic reset_model();
    for (int i = 0; i < NODES; i++) begin
      node_item[i] = '0;
      node_nxt[i] = NIL;
      node_prv[i] = NIL;
      pool_stack[i] = idx_t'(NODES - 1 - i);
    end
    pool_depth = NODES;
    for (int i = 0; i < LISTS; i++) clear_list(lid_t'(i));
  endtask

  task automatic expect_rsp(logic [1:0] st, item_t v, logic ok, lid_t nl, cnt_t cnt,
                            logic lst);
    rsp_t r;
    r.status = st;
    r.item = ok ? v : '0;
    r.item_valid = ok;
    r.new_list = nl;
    r.count = cnt;
    r.last = lst;
    pending_rsp.push_back(r);
  endtask

  task automatic link_node(lid_t l, ptr_t n, ptr_t p, ptr_t q);
    set_prev(n, p);
    set_next(n, q);
    if (p == NIL) lst_head[l] = n; else set_next(p, n);
    if (q == NIL) lst_tail[l] = n; else set_prev(q, n);
    lst_size[l] = lst_size[l] + 1'b1;
    lst_cur[l] = n;
    lst_flags[l] = lst_flags[l] & FL_USE;
  endtask

  task automatic return_node(ptr_t n);
    if (n < NODES && pool_depth < NODES) begin
      pool_stack[pool_depth] = n[IDX_W-1:0];
      pool_depth++;
    end
  endtask

  task automatic unlink(lid_t l, ptr_t n);
    ptr_t p;
    ptr_t q;
    p = link_prev(n);
    q = link_next(n);
    if (p == NIL) lst_head[l] = q; else set_next(p, q);
    if (q == NIL) lst_tail[l] = p; else set_prev(q, p);
    if (lst_size[l] > 0) lst_size[l] = lst_size[l] - 1'b1;
    return_node(n);
  endtask

  // Works out the results of one accepted operation and updates the predicted state.
  task automatic predict_op(logic [3:0] m, lid_t l, lid_t o, item_t it);
    ptr_t   c;
    ptr_t   n;
    ptr_t   q;
    ptr_t   endp;
    flags_t f;
    flags_t mark;
    flags_t opp;
    item_t  v;
    logic   ok;
    int     k;
    cnt_t   left;
    bit     fwd;
    v = '0;
    ok = 1'b0;
    if (m == MODE_NOP) begin
      expect_rsp(ST_OK, '0, 1'b0, '0, is_live(l) ? lst_size[l] : cnt_t'(0), 1'b1);
      return;
    end
    if (m == MODE_CREATE) begin
      for (int i = 0; i < LISTS; i++) begin
        if (!is_live(lid_t'(i))) begin
          clear_list(lid_t'(i));
          lst_flags[i] = FL_USE;
          expect_rsp(ST_OK, '0, 1'b0, lid_t'(i), '0, 1'b1);
          return;
        end
      end
      expect_rsp(ST_POOL, '0, 1'b0, '0, '0, 1'b1);
      return;
    end
    if (!is_live(l) || (m == MODE_CONCAT && !is_live(o))) begin
      expect_rsp(ST_NOLIST, '0, 1'b0, '0, '0, 1'b1);
      return;
    end
    c = lst_cur[l];
    f = lst_flags[l];
    case (m)
      MODE_FIRST, MODE_LAST: begin
        lst_cur[l] = (m == MODE_FIRST) ? lst_head[l] : lst_tail[l];
        lst_flags[l] = FL_USE;
        c = lst_cur[l];
        ok = (c != NIL);
        v = node_val(c);
      end
      MODE_NEXT, MODE_PREV: begin
        fwd = (m == MODE_NEXT);
        mark = fwd ? FL_BEFORE : FL_AFTER;
        opp = fwd ? FL_AFTER : FL_BEFORE;
        endp = fwd ? lst_tail[l] : lst_head[l];
        if ((f & mark) != 0) begin
          c = fwd ? lst_head[l] : lst_tail[l];
          lst_flags[l] = FL_USE;
        end else if ((f & opp) != 0 || c == NIL || c == endp) begin
          c = NIL;
          lst_flags[l] = FL_USE | opp;
        end else begin
          c = fwd ? link_next(c) : link_prev(c);
        end
        lst_cur[l] = c;
        ok = (c != NIL);
        v = node_val(c);
      end
      MODE_CURRENT: begin
        ok = (c != NIL);
        v = node_val(c);
      end
      MODE_ADD, MODE_INSERT, MODE_APPEND, MODE_PREPEND: begin
        if (pool_depth == 0) begin
          expect_rsp(ST_POOL, '0, 1'b0, '0, lst_size[l], 1'b1);
          return;
        end
        pool_depth--;
        n = ptr_t'(pool_stack[pool_depth]);
        node_item[n[IDX_W-1:0]] = it;
        node_nxt[n[IDX_W-1:0]] = NIL;
        node_prv[n[IDX_W-1:0]] = NIL;
        if (m == MODE_PREPEND || (m != MODE_APPEND && (f & FL_BEFORE) != 0))
          link_node(l, n, NIL, lst_head[l]);
        else if (m == MODE_APPEND || (f & FL_AFTER) != 0 || c == NIL)
          link_node(l, n, lst_tail[l], NIL);
        else if (m == MODE_ADD)
          link_node(l, n, c, link_next(c));
        else
          link_node(l, n, link_prev(c), c);
      end
      MODE_REMOVE: begin
        if ((f & (FL_BEFORE | FL_AFTER)) == 0 && c != NIL) begin
          n = link_next(c);
          v = node_val(c);
          ok = 1'b1;
          unlink(l, c);
          lst_cur[l] = (n != NIL) ? n : lst_tail[l];
        end
      end
      MODE_TRIM: begin
        c = lst_tail[l];
        if (lst_size[l] != 0 && c != NIL) begin
          v = node_val(c);
          ok = 1'b1;
          unlink(l, c);
          lst_cur[l] = lst_tail[l];
          lst_flags[l] = FL_USE;
        end
      end
      MODE_CONCAT: begin
        if (l != o) begin
          if (lst_size[l] == 0) begin
            lst_head[l] = lst_head[o];
            lst_tail[l] = lst_tail[o];
            lst_cur[l] = lst_cur[o];
            lst_size[l] = lst_size[o];
            lst_flags[l] = FL_USE | (lst_flags[o] & (FL_BEFORE | FL_AFTER));
          end else if (lst_size[o] != 0) begin
            set_next(lst_tail[l], lst_head[o]);
            set_prev(lst_head[o], lst_tail[l]);
            lst_tail[l] = lst_tail[o];
            lst_size[l] = lst_size[l] + lst_size[o];
          end
          clear_list(o);
        end
      end
      MODE_FREE: begin
        k = 0;
        left = lst_size[l];
        n = lst_head[l];
        while (n != NIL && left > 0 && k < NODES) begin
          q = link_next(n);
          left = left - 1'b1;
          expect_rsp(ST_OK, node_val(n), 1'b1, '0, left, 1'b0);
          return_node(n);
          k++;
          n = q;
        end
        clear_list(l);
        if (k == 0) expect_rsp(ST_OK, '0, 1'b0, '0, '0, 1'b1);
        else pending_rsp[$].last = 1'b1;
        return;
      end
      default: ;
    endcase
    expect_rsp(ST_OK, v, ok, '0, lst_size[l], 1'b1);
  endtask

  // Offers one operation and waits for its transfer; inputs move on the falling edge.
  task automatic send_op(logic [3:0] m, lid_t l, lid_t o, item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.mode = m;
    req.list_id = l;
    req.other_list = o;
    req.item = it;
    do @(posedge clk); while (!req.ready);
    predict_op(m, l, o, it);
  endtask

  task automatic drain_wait();
    @(negedge clk);
    req.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic lid_t pick_live();
    lid_t ids[$];
    for (int i = 0; i < LISTS; i++) if (is_live(lid_t'(i))) ids.push_back(lid_t'(i));
    if (ids.size() == 0) return lid_t'($urandom_range(LISTS - 1));
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cnt < hold_cycles) begin
      rsp.ready = 1'b0;
      hold_cnt = hold_cnt + 1;
    end else begin
      rsp.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.item_out !== e.item) begin
          $error("item_out: expected %h, got %h", e.item, rsp.item_out);
          errors++;
        end
        if (rsp.item_valid !== e.item_valid) begin
          $error("item_valid: expected %0d, got %0d", e.item_valid, rsp.item_valid);
          errors++;
        end
        if (rsp.new_list !== e.new_list) begin
          $error("new_list: expected %0d, got %0d", e.new_list, rsp.new_list);
          errors++;
        end
        if (rsp.count !== e.count) begin
          $error("count: expected %0d, got %0d", e.count, rsp.count);
          errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, rsp.last);
          errors++;
        end
      end
    end
  end

  // every operation, the cursor end cases and the extreme item values
  task automatic test_directed();
    send_op(MODE_COUNT, 3'd5, 3'd0, '0);
    send_op(MODE_CREATE, 3'd0, 3'd0, '0);
    send_op(MODE_NOP, 3'd0, 3'd7, '1);
    send_op(MODE_FIRST, 3'd0, 3'd0, '0);
    send_op(MODE_CURRENT, 3'd0, 3'd0, '0);
    send_op(MODE_NEXT, 3'd0, 3'd0, '0);
    send_op(MODE_PREV, 3'd0, 3'd0, '0);
    send_op(MODE_TRIM, 3'd0, 3'd0, '0);
    send_op(MODE_APPEND, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_op(MODE_PREPEND, 3'd0, 3'd0, 32'h0);
    send_op(MODE_ADD, 3'd0, 3'd0, 32'hA5A5_5A5A);
    send_op(MODE_FIRST, 3'd0, 3'd0, '0);
    send_op(MODE_PREV, 3'd0, 3'd0, '0);
    send_op(MODE_INSERT, 3'd0, 3'd0, 32'h5A5A_A5A5);   // before start: goes to front
    send_op(MODE_LAST, 3'd0, 3'd0, '0);
    send_op(MODE_NEXT, 3'd0, 3'd0, '0);
    send_op(MODE_REMOVE, 3'd0, 3'd0, '0);               // past end: nothing removed
    send_op(MODE_ADD, 3'd0, 3'd0, 32'h1234_5678);
    send_op(MODE_REMOVE, 3'd0, 3'd0, '0);
    send_op(MODE_CREATE, 3'd0, 3'd0, '0);
    send_op(MODE_CONCAT, 3'd0, 3'd0, '0);
    send_op(MODE_CONCAT, 3'd1, 3'd0, '0);               // empty first list takes all
    send_op(MODE_CONCAT, 3'd1, 3'd6, '0);
    send_op(MODE_FREE, 3'd1, 3'd0, '0);
    drain_wait();
  endtask

  task automatic test_create_exhaust();
    for (int i = 0; i < LISTS + 1; i++) send_op(MODE_CREATE, 3'd0, 3'd0, '0);
    send_op(MODE_FREE, 3'd3, 3'd0, '0);
    for (int i = 0; i < LISTS; i++) send_op(MODE_FREE, lid_t'(i), 3'd0, '0);
    drain_wait();
  endtask

  // fills the pool, then frees it behind a long receiver hold-off
  task automatic test_pool_exhaust();
    send_op(MODE_CREATE, 3'd0, 3'd0, '0);
    for (int i = 0; i < NODES; i++) send_op(MODE_APPEND, 3'd0, 3'd0, rand_item());
    send_op(MODE_APPEND, 3'd0, 3'd0, '1);
    send_op(MODE_INSERT, 3'd0, 3'd0, '1);
    drain_wait();
    hold_cycles = 300;
    send_op(MODE_FREE, 3'd0, 3'd0, '0);
    for (int i = 0; i < 6; i++) send_op(MODE_NOP, lid_t'(i), 3'd0, '0);
    drain_wait();
  endtask

  task automatic test_random(int n_ops);
    logic [3:0] m;
    lid_t l;
    lid_t o;
    for (int i = 0; i < n_ops; i++) begin
      l = pick_live();
      o = pick_live();
      if ($urandom_range(19) == 0) l = lid_t'($urandom_range(LISTS - 1));
      if ($urandom_range(19) == 0) o = lid_t'($urandom_range(LISTS - 1));
      case ($urandom_range(15))
        0: m = MODE_CREATE;
        1: m = ($urandom_range(3) == 0) ? MODE_FREE : MODE_CONCAT;
        2: m = ($urandom_range(3) == 0) ? MODE_NOP : MODE_TRIM;
        3, 4: m = MODE_APPEND;
        default: m = 4'($urandom_range(MODE_FREE - 1) + 1);
      endcase
      if (pool_depth < 8 && m >= MODE_ADD && m <= MODE_PREPEND) m = MODE_FREE;
      send_op(m, l, o, rand_item());
    end
    drain_wait();
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = MODE_COUNT;
    req.list_id = '0;
    req.other_list = '0;
    req.item = '0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    stall_pct = 6;
    send_idle_pct = 6;
    test_directed();
    test_create_exhaust();
    send_idle_pct = 0;
    stall_pct = 0;
    test_pool_exhaust();
    test_create_exhaust();

    send_idle_pct = 0;  stall_pct = 0;  test_random(50);
    send_idle_pct = 50; stall_pct = 0;  test_random(50);
    send_idle_pct = 0;  stall_pct = 50; test_random(50);
    send_idle_pct = 6;  stall_pct = 6;  test_random(50);

    if (errors == 0) begin
      $display("pooled_linked_list_manager_tb: PASS");
    end else begin
      $display("pooled_linked_list_manager_tb: FAIL");
    end
    $finish;
  end

endmodule
